[design/spe_pkg.sv]
// Shared constants, types and helper functions of the spring Euler step unit.
package spe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int LEN_W         = 31;
    localparam int TS_W          = 17;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd7;

    localparam logic [LEN_W-1:0]  RST_STIFFNESS   = 31'd65536;
    localparam logic [LEN_W-1:0]  RST_MASS        = 31'd655360;
    localparam logic [TS_W-1:0]   RST_TIME_STEP   = 17'd6554;
    localparam logic [LEN_W-1:0]  RST_REST_LENGTH = 31'd327680;
    localparam logic [WORD_W-1:0] RST_ANCHOR_X    = 32'd0;
    localparam logic [WORD_W-1:0] RST_ANCHOR_Y    = 32'd0;
    localparam logic [WORD_W-1:0] RST_START_X     = 32'd0;
    localparam logic [WORD_W-1:0] RST_START_Y     = 32'd655360;
    localparam logic [LEN_W-1:0]  RST_LENGTH      = 31'd655360;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [LEN_W-1:0]  LEN_MAX  = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] value;
    } clip_t;

    function automatic logic [63:0] sext64(input logic [WORD_W-1:0] v);
        return {{32{v[WORD_W-1]}}, v};
    endfunction

    function automatic clip_t clip32(input logic [63:0] v);
        clip_t r;
        r.hit   = 1'b0;
        r.value = v[WORD_W-1:0];
        if (!v[63] && (v[62:31] != '0))
        begin
            r.hit   = 1'b1;
            r.value = WORD_MAX;
        end
        else if (v[63] && (v[62:31] != '1))
        begin
            r.hit   = 1'b1;
            r.value = WORD_MIN;
        end
        return r;
    endfunction

endpackage

[design/spe_if.sv]
// Step and result channel interfaces of the spring Euler step unit.
interface spe_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface spe_out_if;
    import spe_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] velocity_out;
    logic [WORD_W-1:0] end_y_out;
    logic [LEN_W-1:0]  length_out;
    logic              saturated;

    modport source (output valid, output velocity_out, output end_y_out,
                    output length_out, output saturated, input ready);
    modport sink   (input valid, input velocity_out, input end_y_out,
                    input length_out, input saturated, output ready);
endinterface

[design/spring_euler_step_unit.sv]
// Top level: sequenced spring Euler step with shared multiplier and adder.
//
//  channel    dir  fields                                         handshake
//  step_in    in   restart                                        valid/ready
//  step_out   out  velocity_out, end_y_out, length_out, saturated valid/ready
//  cfg        in   cfg_index, cfg_wdata                           cfg_we
//
// A step runs through the sequencer states from acceptance to the next ready; a
// restart skips the force, division and integration states. The bit-serial
// divider and square root on the shared add/subtract unit make up most of a
// step; a clipped distance skips the square root. Q16.16 when FRAC_BITS is 16.
// Reset loads the configuration defaults and the initial state at once.
// A result waiting on step_out holds the sequencer in its last state until taken.
module spring_euler_step_unit #(
    parameter int FRAC_BITS = spe_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spe_pkg::WORD_W-1:0]     cfg_wdata,
    spe_in_if.sink                         step_in,
    spe_out_if.source                      step_out
);
    import spe_pkg::*;

    localparam int DW = WORD_W + FRAC_BITS;
    localparam int CW = $clog2(DW);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIFF  = 5'd1;
    localparam logic [4:0] S_MULF  = 5'd2;
    localparam logic [4:0] S_NEG   = 5'd3;
    localparam logic [4:0] S_FCLIP = 5'd4;
    localparam logic [4:0] S_FABS  = 5'd5;
    localparam logic [4:0] S_DIV   = 5'd6;
    localparam logic [4:0] S_ACCEL = 5'd7;
    localparam logic [4:0] S_MULDV = 5'd8;
    localparam logic [4:0] S_DV    = 5'd9;
    localparam logic [4:0] S_VEL   = 5'd10;
    localparam logic [4:0] S_MULDY = 5'd11;
    localparam logic [4:0] S_DY    = 5'd12;
    localparam logic [4:0] S_POS   = 5'd13;
    localparam logic [4:0] S_DX    = 5'd14;
    localparam logic [4:0] S_ABSX  = 5'd15;
    localparam logic [4:0] S_DYA   = 5'd16;
    localparam logic [4:0] S_ABSY  = 5'd17;
    localparam logic [4:0] S_MULY  = 5'd18;
    localparam logic [4:0] S_SUM   = 5'd19;
    localparam logic [4:0] S_SQRT  = 5'd20;
    localparam logic [4:0] S_LCLIP = 5'd21;
    localparam logic [4:0] S_DONE  = 5'd22;

    logic [LEN_W-1:0]  stiffness_reg;
    logic [LEN_W-1:0]  mass_reg;
    logic [TS_W-1:0]   time_step_reg;
    logic [LEN_W-1:0]  rest_length_reg;
    logic [WORD_W-1:0] anchor_x_reg;
    logic [WORD_W-1:0] anchor_y_reg;
    logic [WORD_W-1:0] start_x_reg;
    logic [WORD_W-1:0] start_y_reg;

    logic [4:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       prod_reg, prod_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic              sign_reg, sign_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [63:0]       res_reg, res_next;
    logic [32:0]       mag_reg, mag_next;
    logic              big_reg, big_next;
    logic              sat_reg, sat_next;
    logic [WORD_W-1:0] velocity_reg, velocity_next;
    logic [WORD_W-1:0] end_y_reg, end_y_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_velocity_reg, out_velocity_next;
    logic [WORD_W-1:0] out_end_y_reg, out_end_y_next;
    logic [LEN_W-1:0]  out_length_reg, out_length_next;
    logic              out_sat_reg, out_sat_next;

    logic [63:0]        alu_a, alu_b, alu_y;
    logic               alu_sub;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_y;
    logic [63:0]        acc_sh, prod_sh, sq_bit, sq_try;
    logic [31:0]        div_part;
    logic [LEN_W-1:0]   m_eff;
    logic               accept;
    clip_t              clip_r;

    assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + {63'd0, alu_sub};
    assign mul_y   = mul_a * mul_b;
    assign acc_sh  = 64'($signed(acc_reg) >>> FRAC_BITS);
    assign prod_sh = 64'($signed(prod_reg) >>> FRAC_BITS);
    assign sq_bit  = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign sq_try  = res_reg | sq_bit;
    assign div_part = {rem_reg, quo_reg[DW-1]};
    assign m_eff   = (mass_reg == '0) ? LEN_W'(1) : mass_reg;
    assign accept  = step_in.valid && step_in.ready;

    assign step_in.ready          = (state_reg == S_IDLE);
    assign step_out.valid         = out_valid_reg;
    assign step_out.velocity_out  = out_velocity_reg;
    assign step_out.end_y_out     = out_end_y_reg;
    assign step_out.length_out    = out_length_reg;
    assign step_out.saturated     = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= RST_STIFFNESS;
            mass_reg        <= RST_MASS;
            time_step_reg   <= RST_TIME_STEP;
            rest_length_reg <= RST_REST_LENGTH;
            anchor_x_reg    <= RST_ANCHOR_X;
            anchor_y_reg    <= RST_ANCHOR_Y;
            start_x_reg     <= RST_START_X;
            start_y_reg     <= RST_START_Y;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STIFFNESS:   stiffness_reg   <= cfg_wdata[LEN_W-1:0];
                REG_MASS:        mass_reg        <= cfg_wdata[LEN_W-1:0];
                REG_TIME_STEP:   time_step_reg   <= cfg_wdata[TS_W-1:0];
                REG_REST_LENGTH: rest_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_ANCHOR_X:    anchor_x_reg    <= cfg_wdata;
                REG_ANCHOR_Y:    anchor_y_reg    <= cfg_wdata;
                REG_START_X:     start_x_reg     <= cfg_wdata;
                REG_START_Y:     start_y_reg     <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        acc_next          = acc_reg;
        prod_next         = prod_reg;
        w_next            = w_reg;
        sign_next         = sign_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        res_next          = res_reg;
        mag_next          = mag_reg;
        big_next          = big_reg;
        sat_next          = sat_reg;
        velocity_next     = velocity_reg;
        end_y_next        = end_y_reg;
        length_next       = length_reg;
        out_valid_next    = out_valid_reg && !step_out.ready;
        out_velocity_next = out_velocity_reg;
        out_end_y_next    = out_end_y_reg;
        out_length_next   = out_length_reg;
        out_sat_next      = out_sat_reg;
        alu_a             = '0;
        alu_b             = '0;
        alu_sub           = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        clip_r            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sat_next = 1'b0;
                    if (step_in.restart)
                    begin
                        velocity_next = '0;
                        end_y_next    = start_y_reg;
                        state_next    = S_DX;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                alu_a      = {33'd0, length_reg};
                alu_b      = {33'd0, rest_length_reg};
                alu_sub    = 1'b1;
                acc_next   = alu_y;
                state_next = S_MULF;
            end
            S_MULF:
            begin
                mul_a      = {1'b0, stiffness_reg};
                mul_b      = acc_reg[31:0];
                prod_next  = mul_y;
                state_next = S_NEG;
            end
            S_NEG:
            begin
                alu_b      = prod_reg;
                alu_sub    = 1'b1;
                acc_next   = alu_y;
                state_next = S_FCLIP;
            end
            S_FCLIP:
            begin
                clip_r     = clip32(acc_sh);
                w_next     = clip_r.value;
                sign_next  = clip_r.value[WORD_W-1];
                sat_next   = sat_reg | clip_r.hit;
                state_next = S_FABS;
            end
            S_FABS:
            begin
                alu_b      = sext64(w_reg);
                alu_sub    = sign_reg;
                quo_next   = {alu_y[31:0], {FRAC_BITS{1'b0}}};
                rem_next   = '0;
                cnt_next   = CW'(DW - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                alu_a    = {32'd0, div_part};
                alu_b    = {33'd0, m_eff};
                alu_sub  = 1'b1;
                quo_next = {quo_reg[DW-2:0], ~alu_y[63]};
                rem_next = alu_y[63] ? div_part[LEN_W-1:0] : alu_y[LEN_W-1:0];
                if (cnt_reg == '0)
                begin
                    state_next = S_ACCEL;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_ACCEL:
            begin
                alu_b   = {32'd0, quo_reg[31:0]};
                alu_sub = sign_reg;
                w_next  = alu_y[31:0];
                if (!sign_reg && (quo_reg[DW-1:31] != '0))
                begin
                    w_next   = WORD_MAX;
                    sat_next = 1'b1;
                end
                else if (sign_reg && ((quo_reg[DW-1:32] != '0)
                         || (quo_reg[31] && (quo_reg[30:0] != '0))))
                begin
                    w_next   = WORD_MIN;
                    sat_next = 1'b1;
                end
                state_next = S_MULDV;
            end
            S_MULDV:
            begin
                mul_a      = w_reg;
                mul_b      = {15'd0, time_step_reg};
                prod_next  = mul_y;
                state_next = S_DV;
            end
            S_DV:
            begin
                clip_r     = clip32(prod_sh);
                w_next     = clip_r.value;
                sat_next   = sat_reg | clip_r.hit;
                state_next = S_VEL;
            end
            S_VEL:
            begin
                alu_a         = sext64(velocity_reg);
                alu_b         = sext64(w_reg);
                clip_r        = clip32(alu_y);
                velocity_next = clip_r.value;
                sat_next      = sat_reg | clip_r.hit;
                state_next    = S_MULDY;
            end
            S_MULDY:
            begin
                mul_a      = velocity_reg;
                mul_b      = {15'd0, time_step_reg};
                prod_next  = mul_y;
                state_next = S_DY;
            end
            S_DY:
            begin
                clip_r     = clip32(prod_sh);
                w_next     = clip_r.value;
                sat_next   = sat_reg | clip_r.hit;
                state_next = S_POS;
            end
            S_POS:
            begin
                alu_a      = sext64(end_y_reg);
                alu_b      = sext64(w_reg);
                clip_r     = clip32(alu_y);
                end_y_next = clip_r.value;
                sat_next   = sat_reg | clip_r.hit;
                state_next = S_DX;
            end
            S_DX:
            begin
                alu_a      = sext64(start_x_reg);
                alu_b      = sext64(anchor_x_reg);
                alu_sub    = 1'b1;
                acc_next   = alu_y;
                state_next = S_ABSX;
            end
            S_ABSX:
            begin
                alu_b      = acc_reg;
                alu_sub    = acc_reg[63];
                mag_next   = alu_y[32:0];
                big_next   = (alu_y[32:31] != '0);
                state_next = S_DYA;
            end
            S_DYA:
            begin
                alu_a      = sext64(end_y_reg);
                alu_b      = sext64(anchor_y_reg);
                alu_sub    = 1'b1;
                acc_next   = alu_y;
                state_next = S_ABSY;
            end
            S_ABSY:
            begin
                alu_b     = acc_reg;
                alu_sub   = acc_reg[63];
                mag_next  = alu_y[32:0];
                mul_a     = mag_reg[31:0];
                mul_b     = mag_reg[31:0];
                prod_next = mul_y;
                if (big_reg || (alu_y[32:31] != '0))
                begin
                    length_next = LEN_MAX;
                    sat_next    = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                acc_next   = prod_reg;
                mul_a      = mag_reg[31:0];
                mul_b      = mag_reg[31:0];
                prod_next  = mul_y;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                alu_a      = acc_reg;
                alu_b      = prod_reg;
                acc_next   = alu_y;
                res_next   = '0;
                cnt_next   = CW'(31);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                alu_a   = acc_reg;
                alu_b   = sq_try;
                alu_sub = 1'b1;
                if (!alu_y[63])
                begin
                    acc_next = alu_y;
                    res_next = (res_reg >> 1) | sq_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_LCLIP;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_LCLIP:
            begin
                if (res_reg[63:31] != '0)
                begin
                    length_next = LEN_MAX;
                    sat_next    = 1'b1;
                end
                else
                begin
                    length_next = res_reg[LEN_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || step_out.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_velocity_next = velocity_reg;
                    out_end_y_next    = end_y_reg;
                    out_length_next   = length_reg;
                    out_sat_next      = sat_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            velocity_reg  <= '0;
            end_y_reg     <= RST_START_Y;
            length_reg    <= RST_LENGTH;
            sat_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            velocity_reg  <= velocity_next;
            end_y_reg     <= end_y_next;
            length_reg    <= length_next;
            sat_reg       <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        prod_reg         <= prod_next;
        w_reg            <= w_next;
        sign_reg         <= sign_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        res_reg          <= res_next;
        mag_reg          <= mag_next;
        big_reg          <= big_next;
        out_velocity_reg <= out_velocity_next;
        out_end_y_reg    <= out_end_y_next;
        out_length_reg   <= out_length_next;
        out_sat_reg      <= out_sat_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a transaction");

    a_restart_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_in.restart) |=>
            ((velocity_reg == '0) && (end_y_reg == $past(start_y_reg)) && !sat_reg))
        else $error("restart did not reload the initial state");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!out_valid_reg || step_out.ready)) |=>
            (out_valid_reg && (state_reg == S_IDLE) && (out_length_reg == length_reg)))
        else $error("finished result not moved to the output register");

    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |=> ((state_reg == S_SQRT) && (cnt_reg == CW'(31))))
        else $error("square root did not start with a full iteration count");

endmodule
